// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FAC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("check failed");

// Next-cycle implication, disabled while reset is asserted.
`define FAC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("check failed");

`endif

// ===== hdl/fac_pkg.sv =====
// Package of the frustum box cull: types, widths, register indexes and reset values.
package fac_pkg;

	localparam int unsigned COORD_W     = 24;
	localparam int unsigned ELEM_W      = 16;
	localparam int unsigned COEF_W      = ELEM_W + 1;
	localparam int unsigned PROD_W      = COEF_W + COORD_W;
	localparam int unsigned DOT_W       = PROD_W + 2;
	localparam int unsigned COL_W       = 64;
	localparam int unsigned NUM_COLS    = 4;
	localparam int unsigned IN_TDATA_W  = 6 * COORD_W;
	localparam int unsigned OUT_TDATA_W = 8;
	localparam int unsigned CFG_IDX_W   = 2;
	localparam int unsigned NUM_PLANES_DEF = 6;

	localparam logic [COL_W-1:0] COL0_RST = 64'h0000_0000_0000_0100;
	localparam logic [COL_W-1:0] COL1_RST = 64'h0000_0000_0100_0000;
	localparam logic [COL_W-1:0] COL2_RST = 64'h0000_0100_0000_0000;
	localparam logic [COL_W-1:0] COL3_RST = 64'h0100_0000_0000_0000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_COL0 = 2'd0,
		REG_COL1 = 2'd1,
		REG_COL2 = 2'd2,
		REG_COL3 = 2'd3
	} reg_idx_t;

	typedef logic [NUM_COLS-1:0][COL_W-1:0] matrix_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] max_z;
		logic signed [COORD_W-1:0] max_y;
		logic signed [COORD_W-1:0] max_x;
		logic signed [COORD_W-1:0] min_z;
		logic signed [COORD_W-1:0] min_y;
		logic signed [COORD_W-1:0] min_x;
	} box_t;

	// Control travelling down the cell chain alongside each box.
	typedef struct packed {
		logic valid;
		logic vis;
	} cell_ctl_t;

	// Plane coefficient: row three plus or minus row k of one column.
	function automatic logic signed [COEF_W-1:0] plane_coef(
		input logic [COL_W-1:0] col,
		input int unsigned      k,
		input logic             neg
	);
		logic signed [ELEM_W-1:0] w;
		logic signed [ELEM_W-1:0] e;
		w = col[3*ELEM_W +: ELEM_W];
		e = col[k*ELEM_W +: ELEM_W];
		plane_coef = neg ? (COEF_W'(w) - COEF_W'(e)) : (COEF_W'(w) + COEF_W'(e));
	endfunction

endpackage

// ===== hdl/fac_cell.sv =====
// One cell of the cull chain: tests a box against a single frustum plane over two stages.
module fac_cell import fac_pkg::*; #(
	parameter int unsigned PLANE_IDX = 0
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  matrix_t   mtx,
	input  cell_ctl_t ctl_in,
	input  box_t      box_in,
	output cell_ctl_t ctl_out,
	output box_t      box_out
);

	localparam int unsigned K   = PLANE_IDX / 2;
	localparam logic        NEG = (PLANE_IDX % 2) != 0;

	logic signed [COEF_W-1:0] a_raw, b_raw, c_raw, d_raw;
	logic signed [COEF_W-1:0] a, b, c, d;
	logic                     zero_n;
	logic signed [COORD_W-1:0] x, y, z;

	logic signed [PROD_W-1:0] pa_s1, pb_s1, pc_s1;
	logic signed [COEF_W-1:0] d_s1;
	box_t                     box_s1;
	cell_ctl_t                ctl_s1;

	logic signed [DOT_W-1:0]  dot;
	box_t                     box_s2;
	cell_ctl_t                ctl_s2;

	always_comb begin
		a_raw  = plane_coef(mtx[0], K, NEG);
		b_raw  = plane_coef(mtx[1], K, NEG);
		c_raw  = plane_coef(mtx[2], K, NEG);
		d_raw  = plane_coef(mtx[3], K, NEG);
		zero_n = (a_raw == '0) && (b_raw == '0) && (c_raw == '0);
		// A plane with no normal degenerates to y >= 0.
		a = zero_n ? '0 : a_raw;
		b = zero_n ? COEF_W'(1) : b_raw;
		c = zero_n ? '0 : c_raw;
		d = zero_n ? '0 : d_raw;
		// Corner furthest along the normal; a zero coefficient counts as positive.
		x = a[COEF_W-1] ? box_in.min_x : box_in.max_x;
		y = b[COEF_W-1] ? box_in.min_y : box_in.max_y;
		z = c[COEF_W-1] ? box_in.min_z : box_in.max_z;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (en) begin
			ctl_s1 <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pa_s1  <= PROD_W'(a) * PROD_W'(x);
			pb_s1  <= PROD_W'(b) * PROD_W'(y);
			pc_s1  <= PROD_W'(c) * PROD_W'(z);
			d_s1   <= d;
			box_s1 <= box_in;
		end
	end

	assign dot = DOT_W'(pa_s1) + DOT_W'(pb_s1) + DOT_W'(pc_s1) + (DOT_W'(d_s1) <<< 8);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else if (en) begin
			ctl_s2.valid <= ctl_s1.valid;
			ctl_s2.vis   <= ctl_s1.vis & ~dot[DOT_W-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			box_s2 <= box_s1;
		end
	end

	assign ctl_out = ctl_s2;
	assign box_out = box_s2;

endmodule

// ===== hdl/fac_skid.sv =====
// Output register with a skid entry, so that the input ready comes straight from a flop.
module fac_skid import fac_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic                   in_vis,
	output logic                   in_ready,
	output logic                   out_valid,
	output logic                   out_vis,
	input  logic                   out_ready
);

	logic out_valid_q, out_vis_q;
	logic sk_valid_q, sk_vis_q;

	assign in_ready  = ~sk_valid_q;
	assign out_valid = out_valid_q;
	assign out_vis   = out_vis_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			sk_valid_q  <= 1'b0;
		end else if (out_ready || !out_valid_q) begin
			if (sk_valid_q) begin
				out_valid_q <= 1'b1;
				sk_valid_q  <= 1'b0;
			end else begin
				out_valid_q <= in_valid;
			end
		end else if (in_valid && !sk_valid_q) begin
			sk_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready || !out_valid_q) begin
			out_vis_q <= sk_valid_q ? sk_vis_q : in_vis;
		end else if (in_valid && !sk_valid_q) begin
			sk_vis_q <= in_vis;
		end
	end

endmodule

// ===== hdl/frustum_aabb_cull.sv =====
// Top level of the frustum box cull: matrix registers, the chain of plane cells and the output stage.
//
// This block tests one axis-aligned box per transfer against the view frustum of a 4x4
// view-projection matrix held in four column registers, and returns one transfer carrying
// a single visible bit. Each frustum plane is handled by its own cell; the cells form a chain
// and a box moves one stage down it every cycle the chain is not stalled, so a new box is taken
// in each such cycle and the block sustains one box per clock unless stalled. In each cell a box
// is multiplied out, then summed and sign-tested; its result reaches the output after the last
// cell and the output register, and waits there while the downstream side holds tready low.
// The whole chain advances together; when the output register and its skid entry are both full,
// the chain stops and s_tready falls, and it comes from a flop, never from m_tready. The matrix
// may be rewritten only while no box is in flight; a write takes effect for the next box accepted.
module frustum_aabb_cull import fac_pkg::*; #(
	parameter int unsigned NUM_PLANES = NUM_PLANES_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [COL_W-1:0]       cfg_data,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// From bit 0 up: min_x, min_y, min_z, max_x, max_y, max_z, 24 bits each.
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// From bit 0 up: visible, then seven zero bits.
	output logic [OUT_TDATA_W-1:0] m_tdata
);

	matrix_t   mtx_q;
	logic      en;
	logic      vis_out;
	cell_ctl_t ctl [NUM_PLANES+1];
	box_t      box [NUM_PLANES+1];

	// Matrix column registers, reset to the identity.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mtx_q[0] <= COL0_RST;
			mtx_q[1] <= COL1_RST;
			mtx_q[2] <= COL2_RST;
			mtx_q[3] <= COL3_RST;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_COL0: mtx_q[0] <= cfg_data;
				REG_COL1: mtx_q[1] <= cfg_data;
				REG_COL2: mtx_q[2] <= cfg_data;
				REG_COL3: mtx_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	// The head of the chain sees the incoming transfer; every box starts out visible.
	assign s_tready     = en;
	assign ctl[0].valid = s_tvalid;
	assign ctl[0].vis   = 1'b1;
	assign box[0]       = box_t'(s_tdata);

	for (genvar p = 0; p < NUM_PLANES; p++) begin : g_cell
		fac_cell #(
			.PLANE_IDX (p)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.mtx     (mtx_q),
			.ctl_in  (ctl[p]),
			.box_in  (box[p]),
			.ctl_out (ctl[p+1]),
			.box_out (box[p+1])
		);
	end

	fac_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (ctl[NUM_PLANES].valid),
		.in_vis    (ctl[NUM_PLANES].vis),
		.in_ready  (en),
		.out_valid (m_tvalid),
		.out_vis   (vis_out),
		.out_ready (m_tready)
	);

	assign m_tdata = {{(OUT_TDATA_W-1){1'b0}}, vis_out};

endmodule

// ===== hdl/fac_checker.sv =====
// Port-level checker for the frustum box cull, with its bind to the top level.
`include "assert_macros.svh"

module fac_checker import fac_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_tvalid,
	input logic                   s_tready,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [OUT_TDATA_W-1:0] m_tdata
);

	// A stalled result stays offered and unchanged.
	`FAC_ASSERT_NXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid)
	`FAC_ASSERT_NXT(a_out_stable, clk, arst_n, m_tvalid && !m_tready, $stable(m_tdata))
	// The input side only stalls when the output side holds a result.
	`FAC_ASSERT_IMP(a_stall_cause, clk, arst_n, !s_tready, m_tvalid)
	// The padding above the visible bit is always zero.
	`FAC_ASSERT_IMP(a_pad_zero, clk, arst_n, m_tvalid, m_tdata[OUT_TDATA_W-1:1] == '0)

endmodule

bind frustum_aabb_cull fac_checker u_fac_checker (.*);

// ===== tb/frustum_aabb_cull_tb.sv =====
// Self-checking testbench of the frustum box cull: directed and random boxes over several matrices.
`timescale 1ns / 1ps

// Holds the current matrix, the visibility expected for every box in flight, and the error count.
class cull_scoreboard;
	fac_pkg::matrix_t cols;
	bit               expected_vis[$];
	int               errors;

	function new();
		cols   = {fac_pkg::COL3_RST, fac_pkg::COL2_RST, fac_pkg::COL1_RST, fac_pkg::COL0_RST};
		errors = 0;
	endfunction

	function void set_col(fac_pkg::reg_idx_t r, logic [fac_pkg::COL_W-1:0] v);
		cols[r] = v;
	endfunction

	// Plane p is row three plus (p even) or minus (p odd) row p/2. The corner furthest along
	// the normal is tested; a zero normal falls back to the plane y >= 0.
	function bit predict_visible(fac_pkg::box_t b);
		longint lo[3];
		longint hi[3];
		longint coef[4];
		longint w;
		longint e;
		longint dot;
		int     k;
		lo[0] = longint'(b.min_x);
		lo[1] = longint'(b.min_y);
		lo[2] = longint'(b.min_z);
		hi[0] = longint'(b.max_x);
		hi[1] = longint'(b.max_y);
		hi[2] = longint'(b.max_z);
		for (int p = 0; p < fac_pkg::NUM_PLANES_DEF && p < 6; p++) begin
			k = p >> 1;
			for (int c = 0; c < 4; c++) begin
				w = longint'($signed(cols[c][3*fac_pkg::ELEM_W +: fac_pkg::ELEM_W]));
				e = longint'($signed(cols[c][k*fac_pkg::ELEM_W +: fac_pkg::ELEM_W]));
				coef[c] = (p & 1) ? w - e : w + e;
			end
			if (coef[0] == 0 && coef[1] == 0 && coef[2] == 0) begin
				coef = '{0, 1, 0, 0};
			end
			dot = coef[3] * 256;
			for (int i = 0; i < 3; i++) begin
				dot += coef[i] * ((coef[i] >= 0) ? hi[i] : lo[i]);
			end
			if (dot < 0) begin
				return 1'b0;
			end
		end
		return 1'b1;
	endfunction

	function void note_box(fac_pkg::box_t b);
		expected_vis.push_back(predict_visible(b));
	endfunction

	function void check_result(logic [fac_pkg::OUT_TDATA_W-1:0] tdata);
		bit want;
		if (expected_vis.size() == 0) begin
			$error("visible: no result expected, got %0b", tdata[0]);
			errors++;
		end else begin
			want = expected_vis.pop_front();
			if (tdata[0] !== want) begin
				$error("visible: expected %0b, got %0b", want, tdata[0]);
				errors++;
			end
		end
	endfunction

	function int pending();
		return expected_vis.size();
	endfunction
endclass

module frustum_aabb_cull_tb import fac_pkg::*;;

	// One unit in Q16.8 box coordinates, and the extremes of a coordinate field.
	localparam int ONE       = 256;
	localparam int COORD_MAX = 8388607;
	localparam int COORD_MIN = -8388608;
	localparam int PHASES    = 8;
	localparam int PHASE_LEN = 240;

	typedef enum {
		MAT_IDENTITY,
		MAT_SMALL,
		MAT_RANDOM,
		MAT_ALL_MAX,
		MAT_ALL_MIN,
		MAT_ZERO,
		MAT_FLAT_PLANES
	} matrix_kind_t;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [COL_W-1:0]       cfg_data;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;

	// Chance, in percent, that the sender or the receiver sits out a given cycle.
	int unsigned tx_idle_pct = 0;
	int unsigned rx_idle_pct = 0;

	cull_scoreboard sb = new();

	frustum_aabb_cull dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Offers one box, idling beforehand at random, and returns on the edge that takes it.
	// tvalid is left high; the next call or a drain decides what it does next.
	task automatic send_box(box_t b);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		do @(posedge clk); while (!s_tready);
		sb.note_box(b);
	endtask

	// Withdraws the sender and waits until every outstanding result has been collected.
	// The extra edge first keeps the lowering of tvalid in a step of its own.
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
	endtask

	// Writes all four column registers on consecutive edges; only called with nothing in flight.
	task automatic program_matrix(matrix_t m);
		reg_idx_t r;
		r = REG_COL0;
		repeat (NUM_COLS) begin
			cfg_we    <= 1'b1;
			cfg_index <= r;
			cfg_data  <= m[r];
			@(posedge clk);
			sb.set_col(r, m[r]);
			r = r.next();
		end
		cfg_we <= 1'b0;
	endtask

	function automatic matrix_t make_matrix(matrix_kind_t kind);
		matrix_t          m;
		logic [ELEM_W-1:0] w;
		m = '0;
		for (int c = 0; c < NUM_COLS; c++) begin
			for (int r = 0; r < 4; r++) begin
				case (kind)
					MAT_SMALL:   m[c][r*ELEM_W +: ELEM_W] = ELEM_W'($urandom_range(1536) - 768);
					MAT_RANDOM:  m[c][r*ELEM_W +: ELEM_W] = ELEM_W'($urandom);
					MAT_ALL_MAX: m[c][r*ELEM_W +: ELEM_W] = 16'h7FFF;
					MAT_ALL_MIN: m[c][r*ELEM_W +: ELEM_W] = 16'h8000;
					default:     m[c][r*ELEM_W +: ELEM_W] = '0;
				endcase
			end
		end
		if (kind == MAT_IDENTITY) begin
			m = {COL3_RST, COL2_RST, COL1_RST, COL0_RST};
		end else if (kind == MAT_FLAT_PLANES) begin
			// Row 0 equal to row 3 and row 1 its negation in the first three columns, so the
			// second and third planes have zero normals while the others stay general.
			for (int c = 0; c < 3; c++) begin
				w = ELEM_W'($urandom);
				m[c] = {w, ELEM_W'($urandom), -w, w};
			end
			m[3] = {$urandom, $urandom};
		end
		return m;
	endfunction

	function automatic box_t make_box(int mnx, int mny, int mnz, int mxx, int mxy, int mxz);
		box_t b;
		b.min_x = COORD_W'(mnx);
		b.min_y = COORD_W'(mny);
		b.min_z = COORD_W'(mnz);
		b.max_x = COORD_W'(mxx);
		b.max_y = COORD_W'(mxy);
		b.max_z = COORD_W'(mxz);
		return b;
	endfunction

	// Mostly well-formed boxes at a random scale, some inverted ones, and some raw bit noise.
	function automatic box_t random_box();
		logic signed [COORD_W-1:0] lo[3];
		logic signed [COORD_W-1:0] hi[3];
		logic signed [COORD_W-1:0] t;
		int unsigned               roll;
		int unsigned               span;
		roll = $urandom_range(99);
		case ($urandom_range(2))
			0:       span = 23;
			1:       span = 12;
			default: span = 9;
		endcase
		for (int i = 0; i < 3; i++) begin
			if (roll >= 85) begin
				lo[i] = COORD_W'($urandom);
				hi[i] = COORD_W'($urandom);
			end else begin
				lo[i] = COORD_W'(int'($urandom_range((1 << (span + 1)) - 1)) - (1 << span));
				hi[i] = COORD_W'(int'($urandom_range((1 << (span + 1)) - 1)) - (1 << span));
				// Well-formed boxes want min <= max, inverted ones the opposite.
				if ((roll < 70) == (lo[i] > hi[i])) begin
					t     = lo[i];
					lo[i] = hi[i];
					hi[i] = t;
				end
			end
		end
		return {hi[2], hi[1], hi[0], lo[2], lo[1], lo[0]};
	endfunction

	// Receiver: checks every result taken and rolls the ready for the next cycle.
	initial begin
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready) begin
				sb.check_result(m_tdata);
			end
			m_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	initial begin
		matrix_kind_t plan[PHASES];
		plan = '{MAT_IDENTITY, MAT_SMALL, MAT_ALL_MAX, MAT_RANDOM,
		         MAT_ZERO, MAT_FLAT_PLANES, MAT_ALL_MIN, MAT_SMALL};

		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_index <= REG_COL0;
		cfg_data  <= '0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed boxes against the identity matrix left by reset: the frustum is the cube
		// from -1.0 to +1.0 on every axis, so the faces sit at coordinates of -256 and +256.
		tx_idle_pct = 23;
		rx_idle_pct = 83;
		send_box(make_box(0, 0, 0, 0, 0, 0));
		send_box(make_box(-300, 0, 0, -ONE, 0, 0));
		send_box(make_box(-300, 0, 0, -ONE - 1, 0, 0));
		send_box(make_box(ONE, 0, 0, 300, 0, 0));
		send_box(make_box(ONE + 1, 0, 0, 300, 0, 0));
		send_box(make_box(0, -300, 0, 0, -ONE, 0));
		send_box(make_box(0, -300, 0, 0, -ONE - 1, 0));
		send_box(make_box(0, ONE + 1, 0, 0, 300, 0));
		send_box(make_box(0, 0, -300, 0, 0, -ONE));
		send_box(make_box(0, 0, ONE + 1, 0, 0, 300));
		send_box(make_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX));
		send_box(make_box(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN));
		send_box(make_box(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
		send_box(make_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN));
		send_box(make_box(-ONE, -ONE, -ONE, ONE, ONE, ONE));
		// An inverted box whose corners still both land on the faces, so it stays visible.
		send_box(make_box(ONE, ONE, ONE, -ONE, -ONE, -ONE));

		for (int ph = 0; ph < PHASES; ph++) begin
			drain();
			if (ph < 3) begin
				tx_idle_pct = 23;
				rx_idle_pct = 83;
			end else if (ph < 6) begin
				tx_idle_pct = 83;
				rx_idle_pct = 23;
			end else begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			program_matrix(make_matrix(plan[ph]));
			if (plan[ph] == MAT_ZERO) begin
				// Every normal is zero, so each plane reduces to y >= 0 on max_y alone.
				send_box(make_box(-5, -5, -5, 5, 0, 5));
				send_box(make_box(-5, -5, -5, 5, -1, 5));
			end
			for (int n = 0; n < PHASE_LEN; n++) begin
				// Once in the run the sender stops mid-phase until the pipeline is empty.
				if (ph == 1 && n == PHASE_LEN / 2) begin
					drain();
				end
				send_box(random_box());
			end
		end

		drain();
		// Anything that turns up now has no box behind it and is flagged by the receiver.
		repeat (2 * NUM_PLANES_DEF + 8) @(posedge clk);
		if (sb.errors == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	// Watchdog: a correct run takes a small fraction of this even with the heaviest stalling.
	initial begin
		#2_000_000;
		$display("Mismatches found");
		$finish;
	end
endmodule
